/* rtl/core/bbta_pkg.sv */
// Shared types and constants for the bump, back-up and turn avoidance controller.
package bbta_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned AngW   = 16;
  localparam int unsigned SpdW   = 16;
  localparam int unsigned CfgW   = 20;
  localparam int unsigned BdW    = 20;
  localparam int unsigned NearW  = 21;
  localparam int unsigned GainW  = 18;

  // Input item kinds.
  localparam logic [1:0] KIND_ODOM = 2'd0;
  localparam logic [1:0] KIND_BUMP = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Controller phases, as reported on phase_o.
  localparam logic [1:0] MODE_FORWARD  = 2'd0;
  localparam logic [1:0] MODE_BACKWARD = 2'd1;
  localparam logic [1:0] MODE_TURN     = 2'd2;
  localparam logic [1:0] MODE_PAUSE    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FORWARD_SPEED   = 3'd0;
  localparam logic [2:0] CFG_BACKWARD_SPEED  = 3'd1;
  localparam logic [2:0] CFG_BACKWARD_DIST   = 3'd2;
  localparam logic [2:0] CFG_TURN_ANGLE      = 3'd3;
  localparam logic [2:0] CFG_YAW_TOLERANCE   = 3'd4;
  localparam logic [2:0] CFG_TURN_GAIN       = 3'd5;
  localparam logic [2:0] CFG_TURN_RATE_LIMIT = 3'd6;
  localparam logic [2:0] CFG_PAUSE_TICKS     = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [14:0]      FORWARD_SPEED_RST   = 15'd410;
  localparam logic [14:0]      BACKWARD_SPEED_RST  = 15'd410;
  localparam logic [BdW-1:0]   BACKWARD_DIST_RST   = 20'd13107;
  localparam logic [14:0]      TURN_ANGLE_RST      = 15'd10923;
  localparam logic [14:0]      YAW_TOLERANCE_RST   = 15'd1565;
  localparam logic [GainW-1:0] TURN_GAIN_RST       = 18'd77208;
  localparam logic [14:0]      TURN_RATE_LIMIT_RST = 15'd4096;
  localparam logic [7:0]       PAUSE_BEFORE_RST    = 8'd3;
  localparam logic [7:0]       PAUSE_AFTER_RST     = 8'd3;

  // The reverse distance is kept squared, ready for the distance compare.
  localparam logic [2*BdW-1:0] BACKWARD_DIST_SQ_RST =
      (2*BdW)'(BACKWARD_DIST_RST) * (2*BdW)'(BACKWARD_DIST_RST);

endpackage

/* rtl/core/bump_back_turn_avoidance.sv */
// Bump, back-up and turn obstacle avoidance controller (top level).
// A control tick's velocity command appears in the cycle after the request is taken.
// One request per cycle unless output stalls; state update and command are computed in
// a single registered pass (two squares for the distance check, one multiply for the turn).
// Reset: asynchronous, active low; phase FORWARD, positions and headings zero,
// configuration registers at their documented defaults. No clearing pass is needed.
module bump_back_turn_avoidance
  import bbta_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             kind_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [AngW-1:0] heading_i,
  input  logic                   bump_left_i,
  input  logic                   bump_front_i,
  input  logic                   bump_right_i,

  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [SpdW-1:0] linear_speed_o,
  output logic signed [SpdW-1:0] angular_speed_o,
  output logic [1:0]             phase_o,

  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [CfgW-1:0]        cfg_wdata_i
);

  // Configuration registers.
  logic [14:0]        forward_speed_q, backward_speed_q, turn_angle_q;
  logic [14:0]        yaw_tolerance_q, turn_rate_limit_q;
  logic [GainW-1:0]   turn_gain_q;
  logic [2*BdW-1:0]   bd_sq_q;
  logic [7:0]         pause_before_q, pause_after_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forward_speed_q   <= FORWARD_SPEED_RST;
      backward_speed_q  <= BACKWARD_SPEED_RST;
      bd_sq_q           <= BACKWARD_DIST_SQ_RST;
      turn_angle_q      <= TURN_ANGLE_RST;
      yaw_tolerance_q   <= YAW_TOLERANCE_RST;
      turn_gain_q       <= TURN_GAIN_RST;
      turn_rate_limit_q <= TURN_RATE_LIMIT_RST;
      pause_before_q    <= PAUSE_BEFORE_RST;
      pause_after_q     <= PAUSE_AFTER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FORWARD_SPEED:   forward_speed_q   <= cfg_wdata_i[14:0];
        CFG_BACKWARD_SPEED:  backward_speed_q  <= cfg_wdata_i[14:0];
        CFG_BACKWARD_DIST:   bd_sq_q           <= (2*BdW)'(cfg_wdata_i) * (2*BdW)'(cfg_wdata_i);
        CFG_TURN_ANGLE:      turn_angle_q      <= cfg_wdata_i[14:0];
        CFG_YAW_TOLERANCE:   yaw_tolerance_q   <= cfg_wdata_i[14:0];
        CFG_TURN_GAIN:       turn_gain_q       <= cfg_wdata_i[GainW-1:0];
        CFG_TURN_RATE_LIMIT: turn_rate_limit_q <= cfg_wdata_i[14:0];
        CFG_PAUSE_TICKS: begin
          pause_before_q <= cfg_wdata_i[7:0];
          pause_after_q  <= cfg_wdata_i[15:8];
        end
        default: ;
      endcase
    end
  end

  // Controller state.
  logic [1:0]             mode_q, mode_d;
  logic                   resume_turn_q, resume_turn_d;
  logic [PosW-1:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [PosW-1:0]        origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic [AngW-1:0]        cur_heading_q, cur_heading_d, goal_heading_q, goal_heading_d;
  logic                   hit_pending_q, hit_pending_d;
  logic                   hit_right_q, hit_right_d;
  logic                   latched_right_q, latched_right_d;
  logic [7:0]             pause_count_q, pause_count_d;

  logic                   out_valid_q, out_valid_d;
  logic [SpdW-1:0]        lin_q, ang_q, lin_d, ang_d;
  logic [1:0]             phase_q;

  logic                   in_fire, tick;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign tick       = in_fire && (kind_i == KIND_TICK);

  // Distance check: any axis at or beyond 2^21 counts as reached outright.
  logic signed [PosW:0]   dx, dy;
  logic [PosW:0]          ax, ay;
  logic                   far;
  logic [2*NearW:0]       dist_sq;
  logic                   reached;

  always_comb begin
    dx = $signed({cur_x_q[PosW-1], cur_x_q}) - $signed({origin_x_q[PosW-1], origin_x_q});
    dy = $signed({cur_y_q[PosW-1], cur_y_q}) - $signed({origin_y_q[PosW-1], origin_y_q});
    ax = dx[PosW] ? (PosW+1)'(0) - dx : dx;
    ay = dy[PosW] ? (PosW+1)'(0) - dy : dy;
    far = (ax[PosW:NearW] != '0) || (ay[PosW:NearW] != '0);
    dist_sq = (2*NearW+1)'(ax[NearW-1:0] * ax[NearW-1:0])
            + (2*NearW+1)'(ay[NearW-1:0] * ay[NearW-1:0]);
    reached = far || (dist_sq >= (2*NearW+1)'(bd_sq_q));
  end

  // Turn control: heading error wraps modulo a full turn.
  logic [AngW-1:0]        herr;
  logic [AngW:0]          aerr;
  logic [AngW+GainW:0]    rate_prod;
  logic [AngW+GainW-16:0] rate_raw;
  logic [14:0]            rate;
  logic                   aligned;

  always_comb begin
    herr      = goal_heading_q - cur_heading_q;
    aerr      = herr[AngW-1] ? (AngW+1)'(0) - {1'b1, herr} : {1'b0, herr};
    rate_prod = (AngW+GainW+1)'(aerr) * (AngW+GainW+1)'(turn_gain_q);
    rate_raw  = rate_prod[AngW+GainW:16];
    rate      = (rate_raw > (AngW+GainW-15)'(turn_rate_limit_q)) ? turn_rate_limit_q
                                                                  : rate_raw[14:0];
    aligned   = aerr <= (AngW+1)'(yaw_tolerance_q);
  end

  always_comb begin
    mode_d          = mode_q;
    resume_turn_d   = resume_turn_q;
    cur_x_d         = cur_x_q;
    cur_y_d         = cur_y_q;
    cur_heading_d   = cur_heading_q;
    origin_x_d      = origin_x_q;
    origin_y_d      = origin_y_q;
    goal_heading_d  = goal_heading_q;
    hit_pending_d   = hit_pending_q;
    hit_right_d     = hit_right_q;
    latched_right_d = latched_right_q;
    pause_count_d   = pause_count_q;
    lin_d           = '0;
    ang_d           = '0;

    if (in_fire) begin
      case (kind_i)
        KIND_ODOM: begin
          cur_x_d       = pos_x_i;
          cur_y_d       = pos_y_i;
          cur_heading_d = heading_i;
        end
        KIND_BUMP: begin
          // Bumps count only while driving forward; left or front wins over right.
          if (mode_q == MODE_FORWARD) begin
            hit_pending_d = bump_left_i || bump_front_i || bump_right_i;
            hit_right_d   = !(bump_left_i || bump_front_i) && bump_right_i;
          end
        end
        KIND_TICK: begin
          unique case (mode_q)
            MODE_FORWARD: begin
              if (hit_pending_q) begin
                latched_right_d = hit_right_q;
                hit_pending_d   = 1'b0;
                origin_x_d      = cur_x_q;
                origin_y_d      = cur_y_q;
                mode_d          = MODE_BACKWARD;
              end else begin
                lin_d = {1'b0, forward_speed_q};
              end
            end
            MODE_BACKWARD: begin
              if (reached) begin
                goal_heading_d = latched_right_q ? cur_heading_q + {1'b0, turn_angle_q}
                                                 : cur_heading_q - {1'b0, turn_angle_q};
                pause_count_d  = pause_before_q;
                resume_turn_d  = 1'b1;
                mode_d         = MODE_PAUSE;
              end else begin
                lin_d = SpdW'(0) - {1'b0, backward_speed_q};
              end
            end
            MODE_TURN: begin
              if (aligned) begin
                pause_count_d = pause_after_q;
                resume_turn_d = 1'b0;
                mode_d        = MODE_PAUSE;
              end else begin
                ang_d = herr[AngW-1] ? SpdW'(0) - {1'b0, rate} : {1'b0, rate};
              end
            end
            MODE_PAUSE: begin
              // A count of zero or one ends the pause on this tick.
              if (pause_count_q <= 8'd1) begin
                pause_count_d = '0;
                mode_d        = resume_turn_q ? MODE_TURN : MODE_FORWARD;
              end else begin
                pause_count_d = pause_count_q - 8'd1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    if (tick) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_FORWARD;
      resume_turn_q   <= 1'b0;
      cur_x_q         <= '0;
      cur_y_q         <= '0;
      cur_heading_q   <= '0;
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      goal_heading_q  <= '0;
      hit_pending_q   <= 1'b0;
      hit_right_q     <= 1'b0;
      latched_right_q <= 1'b0;
      pause_count_q   <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      mode_q          <= mode_d;
      resume_turn_q   <= resume_turn_d;
      cur_x_q         <= cur_x_d;
      cur_y_q         <= cur_y_d;
      cur_heading_q   <= cur_heading_d;
      origin_x_q      <= origin_x_d;
      origin_y_q      <= origin_y_d;
      goal_heading_q  <= goal_heading_d;
      hit_pending_q   <= hit_pending_d;
      hit_right_q     <= hit_right_d;
      latched_right_q <= latched_right_d;
      pause_count_q   <= pause_count_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      lin_q   <= lin_d;
      ang_q   <= ang_d;
      phase_q <= mode_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign linear_speed_o  = lin_q;
  assign angular_speed_o = ang_q;
  assign phase_o         = phase_q;

  // A control tick always leaves a command in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> out_valid_o)
    else $error("tick request did not produce a command");

  // Only a turn command can carry angular speed, and a turn never drives linearly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (angular_speed_o != '0) |-> (phase_o == MODE_TURN) && (linear_speed_o == '0))
    else $error("angular speed outside a turn");

  // The pause counter is idle outside the pause phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_PAUSE) |-> (pause_count_q == '0))
    else $error("pause counter running outside pause");

  // A pending bump exists only while driving forward.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_pending_q |-> (mode_q == MODE_FORWARD))
    else $error("bump pending outside forward phase");

endmodule
